>>> rtl/dcasr_pkg.sv
// shared types and constants for the dual channel converter readout
`timescale 1ns / 1ps
`default_nettype none
package dcasr_pkg;

    localparam int CODE_W     = 16;
    localparam int SCALE_W    = 32;
    localparam int SCALE_FRAC = 24;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;

    // positive and negative saturation limits of the code
    localparam logic [CODE_W-1:0] CODE_POS_MAX = 16'h7FFF;
    localparam logic [CODE_W-1:0] CODE_NEG_MAX = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIDPOINT    = 2'd0,
        CFG_SCALE       = 2'd1,
        CFG_READY_DELAY = 2'd2
    } t_cfg_idx;

    // pin levels carried with each beat
    typedef struct packed {
        logic conv;
        logic csn;
        logic sclk;
    } t_pins;

    // load enables of the pipeline stages behind the input register
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_en;

endpackage
`default_nettype wire

>>> rtl/dcasr_cfg.sv
// configuration registers: midpoint, scale and ready delay
`timescale 1ns / 1ps
`default_nettype none
module dcasr_cfg #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [dcasr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [dcasr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic signed [SAMPLE_BITS-1:0]           o_midpoint,
    output logic [dcasr_pkg::SCALE_W-1:0]           o_scale,
    output logic [dcasr_pkg::DELAY_W-1:0]           o_ready_delay
);
    import dcasr_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_midpoint;
    logic [SCALE_W-1:0]            r_scale;
    logic [DELAY_W-1:0]            r_ready_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midpoint    <= '0;
            r_scale       <= SCALE_RESET;
            r_ready_delay <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIDPOINT:    r_midpoint    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_SCALE:       r_scale       <= i_cfg_data[SCALE_W-1:0];
                CFG_READY_DELAY: r_ready_delay <= i_cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_midpoint    = r_midpoint;
    assign o_scale       = r_scale;
    assign o_ready_delay = r_ready_delay;

endmodule
`default_nettype wire

>>> rtl/dcasr_quant.sv
// one channel quantizer: offset and magnitude, scale multiply, round and saturate
`timescale 1ns / 1ps
`default_nettype none
module dcasr_quant #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                            i_clk,
    input  wire dcasr_pkg::t_pipe_en             i_en,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sense,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_midpoint,
    input  wire logic [dcasr_pkg::SCALE_W-1:0]   i_scale,
    output logic [dcasr_pkg::CODE_W-1:0]         o_code
);
    import dcasr_pkg::*;

    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int PROD_W  = SAMPLE_BITS + SCALE_W;
    localparam int ROUND_W = PROD_W + 1 - SCALE_FRAC;

    localparam logic [PROD_W:0]    HALF_LSB = (PROD_W + 1)'(1) << (SCALE_FRAC - 1);
    localparam logic [ROUND_W-1:0] POS_LIM  = ROUND_W'(CODE_POS_MAX);
    localparam logic [ROUND_W-1:0] NEG_LIM  = ROUND_W'(CODE_NEG_MAX);

    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_abs;
    logic [PROD_W:0]           rsum;
    logic [ROUND_W-1:0]        rmag;
    logic [CODE_W-1:0]         n_code;

    logic                      r_neg1;
    logic [SAMPLE_BITS-1:0]    r_mag1;
    logic                      r_neg2;
    logic [PROD_W-1:0]         r_prod2;
    logic [CODE_W-1:0]         r_code3;

    // magnitude of the offset sample fits SAMPLE_BITS bits
    assign diff     = DIFF_W'(i_sense) - DIFF_W'(i_midpoint);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // round half away from zero on the magnitude
    assign rsum = {1'b0, r_prod2} + HALF_LSB;
    assign rmag = rsum[PROD_W:SCALE_FRAC];

    always_comb begin
        if (r_neg2) begin
            if (rmag > NEG_LIM) begin
                n_code = CODE_NEG_MAX;
            end else begin
                n_code = CODE_W'(-rmag[CODE_W-1:0]);
            end
        end else begin
            if (rmag > POS_LIM) begin
                n_code = CODE_POS_MAX;
            end else begin
                n_code = rmag[CODE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_neg1 <= diff[DIFF_W-1];
            r_mag1 <= diff_abs[SAMPLE_BITS-1:0];
        end
        if (i_en.ld2) begin
            r_neg2  <= r_neg1;
            r_prod2 <= PROD_W'(r_mag1) * PROD_W'(i_scale);
        end
        if (i_en.ld3) begin
            r_code3 <= n_code;
        end
    end

    assign o_code = r_code3;

endmodule
`default_nettype wire

>>> rtl/dcasr_state.sv
// convert edge, ready timing and serial shifters; state doubles as the result register
`timescale 1ns / 1ps
`default_nettype none
module dcasr_state #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire dcasr_pkg::t_pins               i_pins,
    input  wire logic [TIME_BITS-1:0]           i_now,
    input  wire logic [TIME_BITS-1:0]           i_done_cand,
    input  wire logic [dcasr_pkg::CODE_W-1:0]   i_code_a,
    input  wire logic [dcasr_pkg::CODE_W-1:0]   i_code_b,
    output logic                                o_data_out_a,
    output logic                                o_data_out_b,
    output logic                                o_busy_res,
    output logic                                o_data_ready,
    output logic [dcasr_pkg::CODE_W-1:0]        o_last_code_a,
    output logic [dcasr_pkg::CODE_W-1:0]        o_last_code_b,
    output logic [dcasr_pkg::COUNT_W-1:0]       o_conversion_count
);
    import dcasr_pkg::*;

    logic [CODE_W-1:0]    r_shift_a, r_shift_b, n_shift_a, n_shift_b;
    logic                 r_bit_a, r_bit_b, n_bit_a, n_bit_b;
    logic [CODE_W-1:0]    r_held_a, r_held_b, n_held_a, n_held_b;
    logic                 r_converting, n_converting;
    logic                 r_ready, n_ready;
    logic [TIME_BITS-1:0] r_done_time, n_done_time;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_prev_conv, r_prev_clk;

    logic                 conv_edge;
    logic                 shift_edge;
    logic                 busy_pre;
    logic [TIME_BITS-1:0] since_done;
    logic                 reached;
    logic [CODE_W-1:0]    load_a, load_b;

    always_comb begin
        conv_edge  = i_pins.conv & ~r_prev_conv;
        shift_edge = ~i_pins.csn & i_pins.sclk & ~r_prev_clk;

        n_done_time = conv_edge ? i_done_cand : r_done_time;
        busy_pre    = conv_edge | r_converting;
        // ready once now is at or past done time, modulo the time wrap
        since_done  = i_now - n_done_time;
        reached     = ~since_done[TIME_BITS-1];

        n_converting = busy_pre & ~reached;
        n_ready      = conv_edge ? reached : (r_ready | (r_converting & reached));
        n_count      = r_count + COUNT_W'(conv_edge);
        n_held_a     = conv_edge ? i_code_a : r_held_a;
        n_held_b     = conv_edge ? i_code_b : r_held_b;

        load_a = conv_edge ? i_code_a : r_shift_a;
        load_b = conv_edge ? i_code_b : r_shift_b;

        // msb first, zero fill
        if (shift_edge) begin
            n_bit_a   = load_a[CODE_W-1];
            n_bit_b   = load_b[CODE_W-1];
            n_shift_a = {load_a[CODE_W-2:0], 1'b0};
            n_shift_b = {load_b[CODE_W-2:0], 1'b0};
        end else begin
            n_bit_a   = r_bit_a;
            n_bit_b   = r_bit_b;
            n_shift_a = load_a;
            n_shift_b = load_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_a    <= '0;
            r_shift_b    <= '0;
            r_bit_a      <= 1'b0;
            r_bit_b      <= 1'b0;
            r_held_a     <= '0;
            r_held_b     <= '0;
            r_converting <= 1'b0;
            r_ready      <= 1'b0;
            r_done_time  <= '0;
            r_count      <= '0;
            r_prev_conv  <= 1'b0;
            r_prev_clk   <= 1'b0;
        end else if (i_step) begin
            r_shift_a    <= n_shift_a;
            r_shift_b    <= n_shift_b;
            r_bit_a      <= n_bit_a;
            r_bit_b      <= n_bit_b;
            r_held_a     <= n_held_a;
            r_held_b     <= n_held_b;
            r_converting <= n_converting;
            r_ready      <= n_ready;
            r_done_time  <= n_done_time;
            r_count      <= n_count;
            r_prev_conv  <= i_pins.conv;
            r_prev_clk   <= i_pins.sclk;
        end
    end

    assign o_data_out_a       = r_bit_a;
    assign o_data_out_b       = r_bit_b;
    assign o_busy_res         = r_converting;
    assign o_data_ready       = r_ready;
    assign o_last_code_a      = r_held_a;
    assign o_last_code_b      = r_held_b;
    assign o_conversion_count = r_count;

endmodule
`default_nettype wire

>>> rtl/dual_channel_adc_serial_readout.sv
// top level of the dual channel sampling converter with serial readout
`timescale 1ns / 1ps
`default_nettype none
// Each accepted beat carries one tick of pin levels and both sense samples and
// yields exactly one result beat. The path is five registers deep: input
// register, offset and magnitude, scale multiply, round and saturate, then the
// state update that also forms the result register. Throughput is one beat
// per cycle; each stage holds its beat only while the stage behind it is full
// and stalled. Configuration takes effect on the next clock and is to be
// written with the pipeline empty.
module dual_channel_adc_serial_readout #(
    parameter int SAMPLE_BITS = 24,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [dcasr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [dcasr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [TIME_BITS-1:0]                  i_time_now,
    input  wire logic                                  i_convert_start,
    input  wire logic                                  i_chip_select_n,
    input  wire logic                                  i_serial_clock,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sense_a,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sense_b,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_data_out_a,
    output logic                                       o_data_out_b,
    output logic                                       o_busy_res,
    output logic                                       o_data_ready,
    output logic signed [dcasr_pkg::CODE_W-1:0]        o_last_code_a,
    output logic signed [dcasr_pkg::CODE_W-1:0]        o_last_code_b,
    output logic [dcasr_pkg::COUNT_W-1:0]              o_conversion_count
);
    import dcasr_pkg::*;

    logic signed [SAMPLE_BITS-1:0] midpoint;
    logic [SCALE_W-1:0]            scale;
    logic [DELAY_W-1:0]            ready_delay;

    logic [3:0] r_v;
    logic       r_out_v;
    logic       ld0, ld1, ld2, ld3, ld4;
    t_pipe_en   pipe_en;
    logic       step;

    t_pins                         r_p0_pins, r_p1_pins, r_p2_pins, r_p3_pins;
    logic [TIME_BITS-1:0]          r_p0_now, r_p1_now, r_p2_now, r_p3_now;
    logic [TIME_BITS-1:0]          r_p1_done, r_p2_done, r_p3_done;
    logic signed [SAMPLE_BITS-1:0] r_p0_sense_a, r_p0_sense_b;
    logic [CODE_W-1:0]             code_a, code_b;
    logic [CODE_W-1:0]             last_a, last_b;

    // a stage loads when empty or when its beat moves on
    assign ld4 = ~r_out_v | i_out_ready;
    assign ld3 = ~r_v[3] | ld4;
    assign ld2 = ~r_v[2] | ld3;
    assign ld1 = ~r_v[1] | ld2;
    assign ld0 = ~r_v[0] | ld1;

    assign pipe_en.ld1 = ld1;
    assign pipe_en.ld2 = ld2;
    assign pipe_en.ld3 = ld3;
    assign step        = ld4 & r_v[3];

    assign o_in_ready  = ld0;
    assign o_out_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (ld0) begin
                r_v[0] <= i_in_valid;
            end
            if (ld1) begin
                r_v[1] <= r_v[0];
            end
            if (ld2) begin
                r_v[2] <= r_v[1];
            end
            if (ld3) begin
                r_v[3] <= r_v[2];
            end
            if (ld4) begin
                r_out_v <= r_v[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_p0_pins    <= '{conv: i_convert_start, csn: i_chip_select_n,
                              sclk: i_serial_clock};
            r_p0_now     <= i_time_now;
            r_p0_sense_a <= i_sense_a;
            r_p0_sense_b <= i_sense_b;
        end
        if (ld1) begin
            r_p1_pins <= r_p0_pins;
            r_p1_now  <= r_p0_now;
            // candidate ready time, used only if this beat starts a conversion
            r_p1_done <= r_p0_now + TIME_BITS'(ready_delay);
        end
        if (ld2) begin
            r_p2_pins <= r_p1_pins;
            r_p2_now  <= r_p1_now;
            r_p2_done <= r_p1_done;
        end
        if (ld3) begin
            r_p3_pins <= r_p2_pins;
            r_p3_now  <= r_p2_now;
            r_p3_done <= r_p2_done;
        end
    end

    dcasr_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_midpoint    (midpoint),
        .o_scale       (scale),
        .o_ready_delay (ready_delay)
    );

    dcasr_quant #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_quant_a (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_sense    (r_p0_sense_a),
        .i_midpoint (midpoint),
        .i_scale    (scale),
        .o_code     (code_a)
    );

    dcasr_quant #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_quant_b (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_sense    (r_p0_sense_b),
        .i_midpoint (midpoint),
        .i_scale    (scale),
        .o_code     (code_b)
    );

    dcasr_state #(
        .TIME_BITS (TIME_BITS)
    ) u_state (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_pins             (r_p3_pins),
        .i_now              (r_p3_now),
        .i_done_cand        (r_p3_done),
        .i_code_a           (code_a),
        .i_code_b           (code_b),
        .o_data_out_a       (o_data_out_a),
        .o_data_out_b       (o_data_out_b),
        .o_busy_res         (o_busy_res),
        .o_data_ready       (o_data_ready),
        .o_last_code_a      (last_a),
        .o_last_code_b      (last_b),
        .o_conversion_count (o_conversion_count)
    );

    assign o_last_code_a = signed'(last_a);
    assign o_last_code_b = signed'(last_b);

endmodule
`default_nettype wire
